>>> src/flux_stream_byte_decoder_unit_defines.svh
// Assertion macro used by the fsbd_back scaler.
`ifndef FLUX_STREAM_BYTE_DECODER_UNIT_DEFINES_SVH
`define FLUX_STREAM_BYTE_DECODER_UNIT_DEFINES_SVH
// Check a property on every rising edge of clk outside reset.
`define FSBD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`endif

>>> src/fsbd_pkg.sv
// ----------------------------------------------------------------------------
// fsbd_pkg
// Types and constants of the flux stream byte decoder.
// ----------------------------------------------------------------------------
package fsbd_pkg;

  localparam int INDEX_LIMIT_DEF = 128;
  localparam int PS_PER_TICK_DEF = 41619;
  localparam logic [9:0] REPLAY_RPM_RST = 10'd300;
  localparam logic [9:0] CAPTURE_RPM_RST = 10'd300;
  // divide by 1000 as multiply and shift; exact for every 32-bit dividend
  localparam logic [31:0] RECIP_1000 = 32'h10624DD3;
  localparam int RECIP_SHIFT = 38;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic CFG_REPLAY_RPM = 1'b0;
  localparam logic CFG_CAPTURE_RPM = 1'b1;

  // opcodes and block types
  localparam logic [7:0] OP_SAMPLE2_MAX = 8'h07;
  localparam logic [7:0] OP_NOP1 = 8'h08;
  localparam logic [7:0] OP_NOP2 = 8'h09;
  localparam logic [7:0] OP_NOP3 = 8'h0a;
  localparam logic [7:0] OP_OVF16 = 8'h0b;
  localparam logic [7:0] OP_VAL16 = 8'h0c;
  localparam logic [7:0] OP_OOB = 8'h0d;
  localparam logic [7:0] BLK_READ = 8'h01;
  localparam logic [7:0] BLK_INDEX = 8'h02;
  localparam logic [7:0] BLK_END = 8'h03;
  localparam logic [7:0] BLK_EOF = 8'h0d;

  typedef enum logic [2:0] {
    KIND_FLUX = 3'd0,
    KIND_INDEX = 3'd1,
    KIND_SYNC = 3'd2,
    KIND_EOF = 3'd3,
    KIND_TOO_MANY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_LOW, PH_V16HIGH, PH_SKIP, PH_OTYPE, PH_OSZLO, PH_OSZHI, PH_OPAY
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL1, BK_RECIP, BK_MUL2, BK_DIV, BK_DONE
  } back_state_t;

  // one decoded job: ticks for flux, otherwise the result value
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } job_t;

endpackage

>>> src/fsbd_if.sv
// ----------------------------------------------------------------------------
// fsbd_byte_if / fsbd_result_if
// Valid/ready channels for raw bytes and decoded results.
// ----------------------------------------------------------------------------
interface fsbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;
  logic       last_in_track;
  modport source (output valid, data_byte, track_start, last_in_track, input ready);
  modport sink (input valid, data_byte, track_start, last_in_track, output ready);
endinterface

interface fsbd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [31:0] time_total;
  modport source (output valid, kind, value, time_total, input ready);
  modport sink (input valid, kind, value, time_total, output ready);
endinterface

>>> src/flux_stream_byte_decoder_unit.sv
// ----------------------------------------------------------------------------
// flux_stream_byte_decoder_unit
// Decodes a raw flux capture byte stream into scaled intervals and events.
// ----------------------------------------------------------------------------
// Usage: raw track bytes enter on the bytes channel, one byte per handshake,
// with track_start on the first byte of a track and last_in_track on the
// last. Results leave on the results channel: flux intervals in ns, index
// positions, sync errors, eof and index overflow, each with the running
// interval total. The parser takes a byte in the cycle it is offered and
// pushes a job into a two-entry queue; bytes are refused only while the
// queue is full. An event other than flux moves from the queue into the
// result register once the scaler is idle and no result waits there. A flux
// interval passes a multiply by the tick period, a reciprocal multiply for
// the divide by 1000, a multiply by the replay speed and a 32-step divide by
// the capture speed; no new job is taken while one is in work or a result
// waits. The speed registers are written through cfg_we/cfg_index/cfg_data
// by the user only while idle; the block itself does not enforce it.
// Reset clears the parser, the queue and the total and loads both speed
// registers with 300. When results stalls, the result is held, the queue
// fills and then bytes is held off; nothing is lost.
// ----------------------------------------------------------------------------
module flux_stream_byte_decoder_unit #(
  parameter int INDEX_LIMIT = fsbd_pkg::INDEX_LIMIT_DEF,
  parameter int PS_PER_TICK = fsbd_pkg::PS_PER_TICK_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fsbd_byte_if.sink     bytes,
  fsbd_result_if.source results,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [9:0]    cfg_data
);

  logic           take;
  logic           job_push;
  fsbd_pkg::job_t job;
  fsbd_pkg::job_t q_job;
  logic           q_pop, q_full, q_empty;

  assign bytes.ready = !q_full;
  assign take = bytes.valid && !q_full;

  fsbd_front #(.INDEX_LIMIT(INDEX_LIMIT)) u_front (
    .clk(clk), .rst(rst), .take(take),
    .data_byte(bytes.data_byte), .track_start(bytes.track_start),
    .last_in_track(bytes.last_in_track),
    .job_push(job_push), .job(job)
  );

  fsbd_queue u_queue (
    .clk(clk), .rst(rst), .push(job_push), .push_job(job),
    .pop(q_pop), .pop_job(q_job), .full(q_full), .empty(q_empty)
  );

  fsbd_back #(.PS_PER_TICK(PS_PER_TICK)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_empty(q_empty), .q_job(q_job), .q_pop(q_pop),
    .out_valid(results.valid), .out_ready(results.ready),
    .out_kind(results.kind), .out_value(results.value),
    .out_total(results.time_total)
  );

endmodule

>>> src/fsbd_front.sv
// ----------------------------------------------------------------------------
// fsbd_front
// Byte parser: tracks stream state and emits a job per flux sample or event.
// ----------------------------------------------------------------------------
module fsbd_front #(
  parameter int INDEX_LIMIT = fsbd_pkg::INDEX_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              track_start,
  input  logic              last_in_track,
  output logic              job_push,
  output fsbd_pkg::job_t    job
);

  localparam logic [7:0] LIMIT = 8'(INDEX_LIMIT);

  fsbd_pkg::phase_t phase, phase_next;
  logic [1:0]  skip, skip_next;
  logic [7:0]  high, high_next;
  logic [31:0] ticks, ticks_next;
  logic [31:0] pos, pos_next;
  logic [7:0]  btype, btype_next;
  logic [15:0] bsize, bsize_next;
  logic [15:0] bcount, bcount_next;
  logic [31:0] bword, bword_next;
  logic [7:0]  icount, icount_next;
  logic        stopped, stopped_next;
  logic        act;
  logic        emit;
  fsbd_pkg::job_t job_c;

  // decode one byte
  always_comb begin
    logic [15:0] need;
    logic [31:0] word_c;
    phase_next = phase; skip_next = skip; high_next = high; ticks_next = ticks;
    pos_next = pos; btype_next = btype; bsize_next = bsize; bcount_next = bcount;
    bword_next = bword; icount_next = icount; stopped_next = stopped;
    if (track_start) begin
      phase_next = fsbd_pkg::PH_OPCODE; skip_next = '0; high_next = '0;
      ticks_next = '0; pos_next = '0; btype_next = '0; bsize_next = '0;
      bcount_next = '0; bword_next = '0; icount_next = '0; stopped_next = 1'b0;
    end
    emit = 1'b0;
    act = 1'b0;
    job_c.kind = fsbd_pkg::KIND_FLUX;
    job_c.value = '0;
    need = '0;
    word_c = '0;
    if (!stopped_next) begin
      case (phase_next)
        fsbd_pkg::PH_OPCODE: begin
          if (data_byte == fsbd_pkg::OP_OOB) begin
            phase_next = fsbd_pkg::PH_OTYPE;
          end else begin
            pos_next = pos_next + 32'd1;
            if (data_byte inside {[8'h00:fsbd_pkg::OP_SAMPLE2_MAX]}) begin
              high_next = data_byte;
              phase_next = fsbd_pkg::PH_LOW;
            end else if (data_byte == fsbd_pkg::OP_NOP1) begin
            end else if (data_byte inside {fsbd_pkg::OP_NOP2, fsbd_pkg::OP_NOP3}) begin
              skip_next = 2'(data_byte - fsbd_pkg::OP_NOP1);
              phase_next = fsbd_pkg::PH_SKIP;
            end else if (data_byte == fsbd_pkg::OP_OVF16) begin
              ticks_next = ticks_next + 32'h10000;
            end else if (data_byte == fsbd_pkg::OP_VAL16) begin
              phase_next = fsbd_pkg::PH_V16HIGH;
            end else begin
              emit = 1'b1;
              job_c.value = ticks_next + {24'd0, data_byte};
              ticks_next = '0;
            end
          end
        end
        fsbd_pkg::PH_LOW: begin
          pos_next = pos_next + 32'd1;
          emit = 1'b1;
          job_c.value = ticks_next + {16'd0, high_next, data_byte};
          ticks_next = '0;
          phase_next = fsbd_pkg::PH_OPCODE;
        end
        fsbd_pkg::PH_V16HIGH: begin
          pos_next = pos_next + 32'd1;
          high_next = data_byte;
          phase_next = fsbd_pkg::PH_LOW;
        end
        fsbd_pkg::PH_SKIP: begin
          pos_next = pos_next + 32'd1;
          if (skip_next != 2'd0) skip_next = skip_next - 2'd1;
          if (skip_next == 2'd0) phase_next = fsbd_pkg::PH_OPCODE;
        end
        fsbd_pkg::PH_OTYPE: begin
          btype_next = data_byte;
          phase_next = fsbd_pkg::PH_OSZLO;
        end
        fsbd_pkg::PH_OSZLO: begin
          bsize_next = {8'd0, data_byte};
          phase_next = fsbd_pkg::PH_OSZHI;
        end
        fsbd_pkg::PH_OSZHI: begin
          bsize_next = {data_byte, bsize_next[7:0]};
          bcount_next = '0;
          bword_next = '0;
          if (btype_next == fsbd_pkg::BLK_EOF) begin
            stopped_next = 1'b1;
            phase_next = fsbd_pkg::PH_OPCODE;
            emit = 1'b1;
            job_c.kind = fsbd_pkg::KIND_EOF;
          end else if (bsize_next == 16'd0) begin
            phase_next = fsbd_pkg::PH_OPCODE;
            act = 1'b1;
          end else begin
            phase_next = fsbd_pkg::PH_OPAY;
          end
        end
        default: begin
          word_c = bword_next;
          if (bcount_next < 16'd4) begin
            case (bcount_next[1:0])
              2'd0: word_c[7:0] = data_byte;
              2'd1: word_c[15:8] = data_byte;
              2'd2: word_c[23:16] = data_byte;
              default: word_c[31:24] = data_byte;
            endcase
          end
          bword_next = word_c;
          bcount_next = bcount_next + 16'd1;
          need = (bsize_next < 16'd4) ? bsize_next : 16'd4;
          if (bcount_next == need) act = 1'b1;
          if (bcount_next >= bsize_next) phase_next = fsbd_pkg::PH_OPCODE;
        end
      endcase
      // act on a finished block header or word
      if (act) begin
        if (btype_next inside {fsbd_pkg::BLK_READ, fsbd_pkg::BLK_END}) begin
          if (bword_next != pos_next) begin
            emit = 1'b1;
            job_c.kind = fsbd_pkg::KIND_SYNC;
            job_c.value = pos_next;
          end
        end else if (btype_next == fsbd_pkg::BLK_INDEX) begin
          emit = 1'b1;
          job_c.value = bword_next;
          if (icount_next >= LIMIT) begin
            job_c.kind = fsbd_pkg::KIND_TOO_MANY;
          end else begin
            job_c.kind = fsbd_pkg::KIND_INDEX;
            icount_next = icount_next + 8'd1;
          end
        end
      end
    end
    // drop any unfinished item at track end
    if (last_in_track) begin
      phase_next = fsbd_pkg::PH_OPCODE; skip_next = '0; high_next = '0;
      ticks_next = '0; bcount_next = '0; bword_next = '0;
    end
  end

  // update parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fsbd_pkg::PH_OPCODE; skip <= '0; high <= '0; ticks <= '0;
      pos <= '0; btype <= '0; bsize <= '0; bcount <= '0; bword <= '0;
      icount <= '0; stopped <= 1'b0;
    end else if (take) begin
      phase <= phase_next; skip <= skip_next; high <= high_next; ticks <= ticks_next;
      pos <= pos_next; btype <= btype_next; bsize <= bsize_next; bcount <= bcount_next;
      bword <= bword_next; icount <= icount_next; stopped <= stopped_next;
    end
  end

  assign job_push = take && emit;
  assign job = job_c;

endmodule

>>> src/fsbd_queue.sv
// ----------------------------------------------------------------------------
// fsbd_queue
// Short job queue between parser and scaler.
// ----------------------------------------------------------------------------
module fsbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsbd_pkg::job_t push_job,
  input  logic           pop,
  output fsbd_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int PW = $clog2(fsbd_pkg::QUEUE_DEPTH);

  fsbd_pkg::job_t slots [fsbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr, rd;
  logic [PW:0]   fill;

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0; rd <= '0; fill <= '0;
    end else begin
      if (push) wr <= (wr == PW'(fsbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr + 1'b1;
      if (pop) rd <= (rd == PW'(fsbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr] <= push_job;
  end

  assign pop_job = slots[rd];
  assign full = (fill == (PW+1)'(fsbd_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);

endmodule

>>> src/fsbd_back.sv
// ----------------------------------------------------------------------------
// fsbd_back
// Scaler: converts ticks to speed-scaled ns, keeps the running total, holds the result.
// ----------------------------------------------------------------------------
`include "flux_stream_byte_decoder_unit_defines.svh"
module fsbd_back #(
  parameter int PS_PER_TICK = fsbd_pkg::PS_PER_TICK_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [9:0]     cfg_data,
  input  logic           q_empty,
  input  fsbd_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_kind,
  output logic [31:0]    out_value,
  output logic [31:0]    out_total
);

  localparam logic [31:0] PS = 32'(PS_PER_TICK);

  fsbd_pkg::back_state_t state, state_next;
  logic [9:0]  replay_rpm, capture_rpm;
  logic [31:0] val;
  logic [9:0]  div_d;
  logic [9:0]  rem;
  logic [4:0]  cnt;
  logic [31:0] total;
  logic [10:0] rem_s;
  logic        rem_ge;
  logic [63:0] recip;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fsbd_pkg::BK_IDLE:
        if (!q_empty && !out_valid && q_job.kind == fsbd_pkg::KIND_FLUX)
          state_next = fsbd_pkg::BK_MUL1;
      fsbd_pkg::BK_MUL1: state_next = fsbd_pkg::BK_RECIP;
      fsbd_pkg::BK_RECIP: state_next = fsbd_pkg::BK_MUL2;
      fsbd_pkg::BK_MUL2: state_next = fsbd_pkg::BK_DIV;
      fsbd_pkg::BK_DIV: if (cnt == 5'd0) state_next = fsbd_pkg::BK_DONE;
      fsbd_pkg::BK_DONE: state_next = fsbd_pkg::BK_IDLE;
      default: state_next = fsbd_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = (state == fsbd_pkg::BK_IDLE) && !q_empty && !out_valid;
  end

  // divide by 1000 through the reciprocal
  assign recip = 64'(val) * 64'(fsbd_pkg::RECIP_1000);

  // one restoring divide step
  assign rem_s = {rem, val[31]};
  assign rem_ge = (rem_s >= {1'b0, div_d});

  // hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      replay_rpm <= fsbd_pkg::REPLAY_RPM_RST;
      capture_rpm <= fsbd_pkg::CAPTURE_RPM_RST;
    end else if (cfg_we) begin
      if (cfg_index == fsbd_pkg::CFG_REPLAY_RPM) replay_rpm <= cfg_data;
      else capture_rpm <= cfg_data;
    end
  end

  // advance the sequencer and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsbd_pkg::BK_IDLE;
      out_valid <= 1'b0;
      total <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_pop && q_job.kind != fsbd_pkg::KIND_FLUX) begin
        out_valid <= 1'b1;
        out_total <= total;
      end
      if (state == fsbd_pkg::BK_DONE) begin
        out_valid <= 1'b1;
        total <= total + val;
        out_total <= total + val;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fsbd_pkg::BK_IDLE: begin
        // load only when a job is taken, so a waiting result stays put
        if (q_pop) begin
          val <= q_job.value;
          out_kind <= q_job.kind;
          out_value <= q_job.value;
        end
      end
      fsbd_pkg::BK_MUL1: val <= 32'(val * PS);
      fsbd_pkg::BK_RECIP: val <= 32'(recip >> fsbd_pkg::RECIP_SHIFT);
      fsbd_pkg::BK_DIV: begin
        rem <= rem_ge ? 10'(rem_s - {1'b0, div_d}) : rem_s[9:0];
        val <= {val[30:0], rem_ge};
        cnt <= cnt - 5'd1;
      end
      fsbd_pkg::BK_MUL2: begin
        val <= 32'(val * {22'd0, replay_rpm});
        div_d <= (capture_rpm == 10'd0) ? 10'd1 : capture_rpm;
        rem <= '0;
        cnt <= 5'd31;
      end
      fsbd_pkg::BK_DONE: out_value <= val;
      default: begin
      end
    endcase
  end

  `FSBD_ASSERT(pop_only_when_free, q_pop |-> !out_valid && state == fsbd_pkg::BK_IDLE)
  `FSBD_ASSERT(divisor_nonzero, (state == fsbd_pkg::BK_DIV) |-> div_d != 10'd0)
  `FSBD_ASSERT(done_leads_to_valid, state == fsbd_pkg::BK_DONE |=> out_valid)

endmodule
